### rtl/hagc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hagc_pkg;

  // Field widths fixed by the sample format and the gain format.
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 32;
  localparam int HEADROOM_W = 15;
  localparam int HANG_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HEADROOM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HANG_MAX = 2'd2;

  // Register reset values.
  localparam logic [HEADROOM_W-1:0] HEADROOM_RST = 15'd16384;
  localparam logic [GAIN_W-1:0]     RECOVERY_RST = 32'd1073999626;
  localparam logic [HANG_W-1:0]     HANG_MAX_RST = 20'd48000;
  localparam logic [GAIN_W-1:0]     GAIN_MAX     = 32'hFFFF_FFFF;

  // Upper bound on the amplitude that a full-scale complex sample can produce.
  localparam logic [31:0] AMP_MAX = 32'd46341;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [GAIN_W-1:0]   gain_t;

  // Applies the sign to a magnitude product |s| * gain, rounds the Q.31
  // value to Q1.15 with ties toward plus infinity and saturates it.
  function automatic sample_t scale_round(input logic neg, input logic [63:0] prod);
    logic signed [49:0] mag;
    logic signed [49:0] val;
    logic signed [49:0] rnd;
    logic signed [33:0] res;
    sample_t            out;
    mag = $signed({2'b00, prod[47:0]});
    val = neg ? -mag : mag;
    rnd = val + 50'sd32768;
    res = 34'(rnd >>> 16);
    if (res > 34'sd32767) begin
      out = 16'h7FFF;
    end else if (res < -34'sd32768) begin
      out = 16'h8000;
    end else begin
      out = res[15:0];
    end
    return out;
  endfunction

endpackage

`default_nettype wire

### rtl/hang_agc_sample_scaler_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Hang AGC sample scaler. Each item is one complex baseband sample (signed
// Q1.15 I and Q). The block measures the sample amplitude as the integer
// square root of I*I + Q*Q and compares amplitude times the current gain
// against the programmed headroom. On an overload the gain is recomputed as
// headroom / amplitude and a hang counter is reloaded with hang_max; while the
// counter is nonzero the gain is held and the counter counts down once per
// item; once it is zero the gain grows by the Q2.30 growth multiplier on every
// item, saturating at all ones. The sample is then scaled by the updated gain,
// rounded and saturated to 16 bits, and given out with that gain (Q16.16).
// The gain starts at its maximum after reset. All products run on one shared
// 32 x 32 multiplier; the square root and the division each use a one-bit
// compare-and-subtract step per cycle. A small state machine sequences the
// work, so one item is processed at a time and in_stall stays high while it
// is busy. An item that recovers also passes through S_MUL_RF and S_RECOV,
// and an overload takes longest because the 31-step restoring division
// dominates; the 16-step square root is the other large share. The next
// item can be accepted in the cycle after the result is handed over. A
// finished result waits in the output register, so the next item may be
// accepted while it is still stalled, but that item cannot complete until
// the register has been taken. Configuration writes are always accepted
// (cfg_ready is tied high) and must only be issued while the block is idle;
// writes to an index beyond the register list are ignored.
module hang_agc_sample_scaler_top (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  hagc_pkg::sample_t              in_i_sample,
  input  wire  hagc_pkg::sample_t              in_q_sample,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output hagc_pkg::sample_t                    out_i,
  output hagc_pkg::sample_t                    out_q,
  output hagc_pkg::gain_t                      out_gain_now,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [hagc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [hagc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import hagc_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL_I   = 4'd1;
  localparam logic [3:0] S_MUL_Q   = 4'd2;
  localparam logic [3:0] S_SUMP    = 4'd3;
  localparam logic [3:0] S_SQRT    = 4'd4;
  localparam logic [3:0] S_MUL_AG  = 4'd5;
  localparam logic [3:0] S_CMP     = 4'd6;
  localparam logic [3:0] S_DIV     = 4'd7;
  localparam logic [3:0] S_MUL_RF  = 4'd8;
  localparam logic [3:0] S_RECOV   = 4'd9;
  localparam logic [3:0] S_SCALE_I = 4'd10;
  localparam logic [3:0] S_SCALE_Q = 4'd11;
  localparam logic [3:0] S_FIN     = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  // Control and configuration state.
  logic [3:0]            state_r,    state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  gain_t                 gain_r,     gain_nxt;
  logic [HANG_W-1:0]     hang_r,     hang_nxt;
  logic [HEADROOM_W-1:0] headroom_r, headroom_nxt;
  gain_t                 rf_r,       rf_nxt;
  logic [HANG_W-1:0]     hang_max_r, hang_max_nxt;

  // Datapath registers.
  logic                  neg_i_r, neg_i_nxt;
  logic                  neg_q_r, neg_q_nxt;
  sample_t               ai_r,    ai_nxt;
  sample_t               aq_r,    aq_nxt;
  logic [63:0]           prod_r,  prod_nxt;
  logic [31:0]           rem_r,   rem_nxt;
  logic [31:0]           root_r,  root_nxt;
  logic [4:0]            cnt_r,   cnt_nxt;
  logic [15:0]           drem_r,  drem_nxt;
  logic [30:0]           quo_r,   quo_nxt;
  sample_t               oi_r,    oi_nxt;
  sample_t               oq_r,    oq_nxt;
  sample_t               out_i_r, out_i_nxt;
  sample_t               out_q_r, out_q_nxt;
  gain_t                 out_g_r, out_g_nxt;

  // Shared multiplier operands.
  logic [31:0]           mul_a;
  logic [31:0]           mul_b;

  // Square root step.
  logic [31:0]           sq_bit;
  logic [32:0]           sq_sum;
  logic                  sq_take;

  // Division step.
  logic [15:0]           amp;
  logic [16:0]           dv_shift;
  logic [16:0]           dv_diff;
  logic                  dv_take;

  logic [63:0]           limit64;
  logic                  in_acc;
  logic                  out_acc;
  logic                  load_out;

  assign in_stall     = (state_r != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_i        = out_i_r;
  assign out_q        = out_q_r;
  assign out_gain_now = out_g_r;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign amp      = root_r[15:0];
  assign limit64  = {33'd0, headroom_r, 16'd0};

  // Square root: one result bit per cycle, bit = 4^cnt.
  assign sq_bit  = 32'd1 << {cnt_r[3:0], 1'b0};
  assign sq_sum  = {1'b0, root_r} + {1'b0, sq_bit};
  assign sq_take = ({1'b0, rem_r} >= sq_sum);

  // Restoring division: one quotient bit per cycle.
  assign dv_shift = {drem_r, quo_r[30]};
  assign dv_diff  = dv_shift - {1'b0, amp};
  assign dv_take  = (dv_shift >= {1'b0, amp});

  always_comb begin
    case (state_r)
      S_MUL_I: begin
        mul_a = {16'd0, ai_r};
        mul_b = {16'd0, ai_r};
      end
      S_MUL_Q: begin
        mul_a = {16'd0, aq_r};
        mul_b = {16'd0, aq_r};
      end
      S_MUL_AG: begin
        mul_a = {16'd0, amp};
        mul_b = gain_r;
      end
      S_MUL_RF: begin
        mul_a = gain_r;
        mul_b = rf_r;
      end
      S_SCALE_I: begin
        mul_a = {16'd0, ai_r};
        mul_b = gain_r;
      end
      S_SCALE_Q: begin
        mul_a = {16'd0, aq_r};
        mul_b = gain_r;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    gain_nxt      = gain_r;
    hang_nxt      = hang_r;
    headroom_nxt  = headroom_r;
    rf_nxt        = rf_r;
    hang_max_nxt  = hang_max_r;
    neg_i_nxt     = neg_i_r;
    neg_q_nxt     = neg_q_r;
    ai_nxt        = ai_r;
    aq_nxt        = aq_r;
    prod_nxt      = 64'(mul_a) * 64'(mul_b);
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    cnt_nxt       = cnt_r;
    drem_nxt      = drem_r;
    quo_nxt       = quo_r;
    oi_nxt        = oi_r;
    oq_nxt        = oq_r;
    out_i_nxt     = out_i_r;
    out_q_nxt     = out_q_r;
    out_g_nxt     = out_g_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_HEADROOM: headroom_nxt = cfg_data[HEADROOM_W-1:0];
        CFG_RECOVERY: rf_nxt       = cfg_data[GAIN_W-1:0];
        CFG_HANG_MAX: hang_max_nxt = cfg_data[HANG_W-1:0];
        default: ;
      endcase
    end

    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          neg_i_nxt = in_i_sample[15];
          neg_q_nxt = in_q_sample[15];
          ai_nxt    = in_i_sample[15] ? (~in_i_sample + 16'd1) : in_i_sample;
          aq_nxt    = in_q_sample[15] ? (~in_q_sample + 16'd1) : in_q_sample;
          state_nxt = S_MUL_I;
        end
      end
      S_MUL_I: begin
        state_nxt = S_MUL_Q;
      end
      S_MUL_Q: begin
        rem_nxt   = prod_r[31:0];
        state_nxt = S_SUMP;
      end
      S_SUMP: begin
        // I*I + Q*Q is at most 2^31 and always fits.
        rem_nxt   = rem_r + prod_r[31:0];
        root_nxt  = 32'd0;
        cnt_nxt   = 5'd15;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (sq_take) begin
          rem_nxt  = rem_r - sq_sum[31:0];
          root_nxt = (root_r >> 1) + sq_bit;
        end else begin
          root_nxt = root_r >> 1;
        end
        if (cnt_r == 5'd0) begin
          state_nxt = S_MUL_AG;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      S_MUL_AG: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (prod_r > limit64) begin
          drem_nxt  = 16'd0;
          quo_nxt   = {headroom_r, 16'd0};
          cnt_nxt   = 5'd30;
          state_nxt = S_DIV;
        end else if (hang_r != '0) begin
          hang_nxt  = hang_r - {{(HANG_W-1){1'b0}}, 1'b1};
          state_nxt = S_SCALE_I;
        end else begin
          state_nxt = S_MUL_RF;
        end
      end
      S_DIV: begin
        drem_nxt = dv_take ? dv_diff[15:0] : dv_shift[15:0];
        quo_nxt  = {quo_r[29:0], dv_take};
        if (cnt_r == 5'd0) begin
          gain_nxt  = {1'b0, quo_r[29:0], dv_take};
          hang_nxt  = hang_max_r;
          state_nxt = S_SCALE_I;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      S_MUL_RF: begin
        state_nxt = S_RECOV;
      end
      S_RECOV: begin
        gain_nxt  = (prod_r[63:62] != 2'b00) ? GAIN_MAX : prod_r[61:30];
        state_nxt = S_SCALE_I;
      end
      S_SCALE_I: begin
        state_nxt = S_SCALE_Q;
      end
      S_SCALE_Q: begin
        oi_nxt    = scale_round(neg_i_r, prod_r);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        oq_nxt    = scale_round(neg_q_r, prod_r);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          out_i_nxt     = oi_r;
          out_q_nxt     = oq_r;
          out_g_nxt     = gain_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gain_r      <= GAIN_MAX;
      hang_r      <= '0;
      headroom_r  <= HEADROOM_RST;
      rf_r        <= RECOVERY_RST;
      hang_max_r  <= HANG_MAX_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      gain_r      <= gain_nxt;
      hang_r      <= hang_nxt;
      headroom_r  <= headroom_nxt;
      rf_r        <= rf_nxt;
      hang_max_r  <= hang_max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_i_r <= neg_i_nxt;
    neg_q_r <= neg_q_nxt;
    ai_r    <= ai_nxt;
    aq_r    <= aq_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    cnt_r   <= cnt_nxt;
    drem_r  <= drem_nxt;
    quo_r   <= quo_nxt;
    oi_r    <= oi_nxt;
    oq_r    <= oq_nxt;
    out_i_r <= out_i_nxt;
    out_q_r <= out_q_nxt;
    out_g_r <= out_g_nxt;
  end

`ifndef ASSERT_OFF
  // The gain only changes in the update states, never during the square root.
  a_gain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |=> $stable(gain_r))
    else $error("gain changed during the square root");

  // A new result only appears when the sequencer hands one over.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside the hand-over state");

  // The amplitude of a 16-bit complex sample never exceeds sqrt(2) full scale.
  a_amp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL_AG) |-> (root_r <= AMP_MAX))
    else $error("square root out of range");

  // An overload implies a nonzero amplitude, so the divisor is never zero.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (amp != 16'd0))
    else $error("division by zero amplitude");
`endif

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps

// Checks the hang AGC sample scaler item by item. Every accepted complex sample is run
// through a scoreboard-side copy of the gain loop. That copy is the amplitude measurement,
// the overload test against the headroom, the hang countdown and the recovery growth.
// The scaled I/Q and gain it yields are queued and compared with each result the block
// hands out. Both handshakes are throttled at random so that gaps land on every phase of
// the block's multi-cycle work.
module tb_top;
  import hagc_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  // Settle time that covers the slowest item (an overload), with headroom on top.
  localparam int SETTLE_CYCLES = 80;
  localparam int MAX_REPORTS   = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [31:0] UNITY_Q30 = 32'h4000_0000;

  typedef struct packed {
    sample_t i;
    sample_t q;
    gain_t   gain;
  } scaled_sample_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  sample_t               in_i_sample  = '0;
  sample_t               in_q_sample  = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  sample_t               out_i;
  sample_t               out_q;
  gain_t                 out_gain_now;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  hang_agc_sample_scaler_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_i_sample  (in_i_sample),
    .in_q_sample  (in_q_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_i        (out_i),
    .out_q        (out_q),
    .out_gain_now (out_gain_now),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the register file and of the gain loop state, both at reset values.
  logic [HEADROOM_W-1:0] headroom_reg = HEADROOM_RST;
  gain_t                 recovery_reg = RECOVERY_RST;
  logic [HANG_W-1:0]     hang_max_reg = HANG_MAX_RST;
  gain_t                 gain_track   = GAIN_MAX;
  logic [HANG_W-1:0]     hang_track   = '0;

  scaled_sample_t scaled_expected[$];

  // Percent chance per opportunity that the sender inserts a gap or the receiver stalls.
  // Tests change these to get stretches that run flat out and stretches under pressure.
  int gap_pct   = 30;
  int stall_pct = 30;

  int mismatches   = 0;
  int n_items      = 0;
  int n_checked    = 0;
  int n_cfg_writes = 0;
  int n_overloads  = 0;
  int n_holds      = 0;
  int n_recoveries = 0;
  int n_gain_max   = 0;
  int cycles       = 0;
  int stall_left   = 0;

  // Integer square root, built one result bit at a time from the top.
  // The power never exceeds 2^31, so 16 result bits are enough.
  function automatic logic [31:0] int_sqrt(input logic [31:0] power);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= 64'(power)) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Scales a Q1.15 sample by a Q16.16 gain.
  // Rounding is half up toward plus infinity, and the result saturates to 16 bits.
  function automatic sample_t apply_gain(input sample_t s, input gain_t g);
    logic signed [63:0] prod;
    logic signed [63:0] rounded;
    prod    = 64'($signed(s)) * $signed({32'd0, g});
    rounded = (prod + 64'sd32768) >>> 16;
    if (rounded > 64'sd32767) begin
      return 16'h7FFF;
    end
    if (rounded < -64'sd32768) begin
      return 16'h8000;
    end
    return rounded[15:0];
  endfunction

  // Advances the gain loop by one sample and queues the result the block should produce.
  task automatic agc_predict(input sample_t i_s, input sample_t q_s);
    logic signed [63:0] si;
    logic signed [63:0] sq;
    logic [31:0]        power;
    logic [63:0]        amp;
    logic [63:0]        limit;
    logic [63:0]        grown;
    scaled_sample_t     r;
    si    = 64'($signed(i_s));
    sq    = 64'($signed(q_s));
    power = 32'(si * si + sq * sq);
    amp   = 64'(int_sqrt(power));
    limit = 64'(headroom_reg) << 16;
    if (amp * 64'(gain_track) > limit) begin
      // Overload: pull the gain down so that this amplitude lands on the headroom.
      gain_track = 32'(limit / amp);
      hang_track = hang_max_reg;
      n_overloads++;
    end else if (hang_track != '0) begin
      hang_track = hang_track - 1'b1;
      n_holds++;
    end else begin
      grown      = (64'(gain_track) * 64'(recovery_reg)) >> 30;
      gain_track = (grown > 64'(GAIN_MAX)) ? GAIN_MAX : grown[31:0];
      n_recoveries++;
    end
    if (gain_track == GAIN_MAX) begin
      n_gain_max++;
    end
    r.i    = apply_gain(i_s, gain_track);
    r.q    = apply_gain(q_s, gain_track);
    r.gain = gain_track;
    scaled_expected.push_back(r);
    n_items++;
  endtask

  // Length of one idle stretch. Most are short, some are medium and a few are long.
  function automatic int idle_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 80) begin
      return $urandom_range(3, 1);
    end
    if (roll < 95) begin
      return $urandom_range(10, 4);
    end
    return $urandom_range(60, 20);
  endfunction

  // Draws a sample whose magnitude is set by a random right shift.
  // A shift of 0 gives a full-scale random value and 15 leaves only the sign.
  // Exact full scale and zero are mixed in at a low rate.
  function automatic sample_t shaped_sample(input int shift_lo, input int shift_hi);
    int unsigned        roll;
    logic signed [15:0] v;
    roll = $urandom_range(99);
    v    = 16'($urandom());
    if (roll < 4) begin
      return 16'h7FFF;
    end
    if (roll < 8) begin
      return 16'h8000;
    end
    if (roll < 11) begin
      return '0;
    end
    v = v >>> $urandom_range(shift_hi, shift_lo);
    return v;
  endfunction

  // Offers one item, optionally after a random gap, and predicts it once it is taken.
  // When there is no gap, in_valid stays high from the previous item and is not
  // dropped in between.
  task automatic send_sample(input sample_t i_s, input sample_t q_s);
    int gap;
    gap = (gap_pct != 0 && $urandom_range(99) < gap_pct) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_i_sample <= i_s;
    in_q_sample <= q_s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    agc_predict(i_s, q_s);
  endtask

  // Stops offering items until every queued result has come back.
  // Then it waits out the slowest item's latency so that the block is truly idle.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (scaled_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One configuration write. cfg_valid is left high so that back-to-back writes
  // do not drop it in between. program_regs lowers it at the end.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    n_cfg_writes++;
    case (idx)
      CFG_HEADROOM: headroom_reg = data[HEADROOM_W-1:0];
      CFG_RECOVERY: recovery_reg = data;
      CFG_HANG_MAX: hang_max_reg = data[HANG_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all three registers, preceded by a junk write to the unused index.
  // The block must ignore that junk write. Values are passed raw, so bits above a
  // register's width reach the block and must be dropped there.
  task automatic program_regs(input logic [31:0] headroom, input logic [31:0] recovery,
                              input logic [31:0] hang_max);
    write_reg(CFG_SPARE, $urandom());
    write_reg(CFG_HEADROOM, headroom);
    write_reg(CFG_RECOVERY, recovery);
    write_reg(CFG_HANG_MAX, hang_max);
    cfg_valid <= 1'b0;
  endtask

  // Random settings that keep the gain alive.
  // The headroom is never zero, and the recovery factor is never below one.
  task automatic random_regs(input int hang_cap);
    program_regs(($urandom() & 32'hFFFF_8000) | $urandom_range(32767, 1),
                 $urandom_range(32'hFFFF_FFFF, UNITY_Q30),
                 ($urandom() & 32'hFFF0_0000) | $urandom_range(hang_cap, 0));
  endtask

  // Realistic signal shape. Loud bursts trigger overloads. Quiet runs let the hang
  // counter expire and the gain climb back. Short noisy stretches are mixed in.
  task automatic send_segments(input int count);
    int left;
    int kind;
    int seg;
    int lo;
    int hi;
    left = count;
    while (left > 0) begin
      kind = $urandom_range(9);
      if (kind < 3) begin
        lo  = 0;
        hi  = 2;
        seg = $urandom_range(6, 1);
      end else if (kind < 8) begin
        lo  = 6;
        hi  = 15;
        seg = $urandom_range(30, 4);
      end else begin
        lo  = 0;
        hi  = 15;
        seg = $urandom_range(10, 1);
      end
      for (int k = 0; k < seg && left > 0; k++) begin
        send_sample(shaped_sample(lo, hi), shaped_sample(lo, hi));
        left--;
      end
    end
  endtask

  // Reset settings with the gain at its maximum. These items are the full-scale
  // corners, including the diagonal whose amplitude goes above full scale.
  task automatic test_full_scale_extremes();
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h7FFF, 16'h0000);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h0001, 16'hFFFF);
    send_sample(16'h7FFF, 16'h7FFF);
    wait_for_results();
  endtask

  // A short hang lets one overload, its hold and the doubling recovery be seen in a
  // few items. The hang value carries junk above bit 19, which must be dropped.
  task automatic test_hang_then_recovery();
    program_regs(32'd16384, 32'h8000_0000, 32'hFFF0_0002);
    send_sample(16'h7FFF, 16'h7FFF);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h0004, 16'hFFFC);
    send_sample(16'h0100, 16'hFF00);
    wait_for_results();
  endtask

  // Every register is written with all ones. That gives the largest headroom,
  // the largest growth factor and the longest hang once the masks are applied.
  task automatic test_register_maxima();
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h0002, 16'hFFFD);
    send_sample(16'h8000, 16'h0000);
    send_sample(16'h7FFF, 16'h7FFF);
    wait_for_results();
  endtask

  // Main random traffic over several settings. Halfway through each round the sender
  // holds off until the result queue is empty.
  task automatic test_random_bursts();
    for (int round = 0; round < 4; round++) begin
      random_regs(20);
      send_segments(50);
      wait_for_results();
      send_segments(50);
      wait_for_results();
    end
  endtask

  // Zero hang with fast recovery. Neither side idles, so items move as fast as the
  // block allows.
  task automatic test_zero_hang_no_idle();
    gap_pct   = 0;
    stall_pct = 0;
    program_regs($urandom_range(32767, 1), 32'h8000_0000, 32'd0);
    send_segments(100);
    wait_for_results();
    gap_pct   = 30;
    stall_pct = 30;
  endtask

  // The receiver stalls most of the time.
  // Finished results then sit in the output register while the next item is in flight.
  task automatic test_heavy_backpressure();
    stall_pct = 70;
    gap_pct   = 10;
    random_regs(8);
    send_segments(60);
    wait_for_results();
    stall_pct = 30;
    gap_pct   = 30;
  endtask

  // These settings kill the gain, so this test runs last. With zero headroom, a
  // nonzero sample overloads and the gain drops to zero. A zero growth factor then
  // keeps it there. The headroom value is all junk above bit 14.
  task automatic test_gain_collapse();
    program_regs(32'hFFFF_8000, UNITY_Q30, 32'd1);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h012C, 16'hFFF9);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000);
    wait_for_results();
    program_regs(32'h0000_7FFF, 32'd0, 32'd0);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h0000, 16'h0000);
    wait_for_results();
  endtask

  // Compares one handed-out result with the oldest queued prediction.
  task automatic check_result();
    scaled_sample_t want;
    n_checked++;
    if (scaled_expected.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("Result with nothing expected: i %0d q %0d gain %h",
                 $signed(out_i), $signed(out_q), out_gain_now);
      end
    end else begin
      want = scaled_expected.pop_front();
      if (out_i !== want.i || out_q !== want.q || out_gain_now !== want.gain) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Result %0d wrong: i exp %0d got %0d, q exp %0d got %0d, gain exp %h got %h",
                   n_checked, $signed(want.i), $signed(out_i), $signed(want.q),
                   $signed(out_q), want.gain, out_gain_now);
        end
      end
    end
  endtask

  // Result side. A result is taken at any edge with out_valid high and out_stall low.
  // The stall pattern for the following cycle is chosen at that same edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_result();
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left = idle_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, scaled_expected.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_full_scale_extremes();
    test_hang_then_recovery();
    test_register_maxima();
    test_random_bursts();
    test_zero_hang_no_idle();
    test_heavy_backpressure();
    test_gain_collapse();
    // Nothing is outstanding now, and the settle time after the last item has passed.
    $display("Covered %0d samples, %0d results checked, %0d register writes.",
             n_items, n_checked, n_cfg_writes);
    $display("Gain loop saw %0d overloads, %0d hang holds, %0d recovery steps, %0d at max.",
             n_overloads, n_holds, n_recoveries, n_gain_max);
    if (mismatches == 0 && scaled_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
